[hdl/sks_pkg.sv]
package sks_pkg;

    localparam int DEPTH_DEFAULT     = 64;
    localparam int KEY_WIDTH_DEFAULT = 32;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    typedef enum logic
    {
        S_IDLE,
        S_EVAL
    } state_t;

    // Sequencer strobes seen by the datapath.
    typedef struct packed
    {
        logic busy;
        logic capture;
        logic eval;
    } seq_t;

    // Per-cell controls broadcast along the chain.
    typedef struct packed
    {
        logic cmp_en;
        logic shift_en;
    } cell_ctl_t;

endpackage

[hdl/sks_cell.sv]
module sks_cell #(
    parameter int KEY_WIDTH = sks_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sks_pkg::cell_ctl_t    ctl,
    input  logic [KEY_WIDTH-1:0]  probe,
    input  logic [KEY_WIDTH-1:0]  ins_key,
    input  logic [KEY_WIDTH-1:0]  left_key,
    input  logic                  left_valid,
    input  logic                  left_gt,
    output logic [KEY_WIDTH-1:0]  slot_key,
    output logic                  slot_valid,
    output logic                  gt,
    output logic                  eq
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 gt_reg;
    logic                 eq_reg;

    // The chain is sorted, so the cells that hold keys above the probe form a
    // prefix. The first cell outside that prefix takes the new key and every
    // cell after it takes its left neighbor's contents.
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctl.shift_en && !gt_reg)
        begin
            if (left_gt)
            begin
                key_next   = ins_key;
                valid_next = 1'b1;
            end
            else
            begin
                key_next   = left_key;
                valid_next = left_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (ctl.cmp_en)
        begin
            gt_reg <= valid_reg && (key_reg > probe);
            eq_reg <= valid_reg && (key_reg == probe);
        end
    end

    assign slot_key   = key_reg;
    assign slot_valid = valid_reg;
    assign gt         = gt_reg;
    assign eq         = eq_reg;

endmodule

[hdl/sks_ctrl.sv]
module sks_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output sks_pkg::seq_t seq
);

    sks_pkg::state_t state_reg;
    sks_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sks_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = sks_pkg::S_EVAL;
                end
            end
            sks_pkg::S_EVAL:
            begin
                state_next = sks_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sks_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        seq = '0;
        case (state_reg)
            sks_pkg::S_IDLE:
            begin
                seq.capture = start;
            end
            sks_pkg::S_EVAL:
            begin
                seq.busy = 1'b1;
                seq.eval = 1'b1;
            end
            default:
            begin
                seq = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sks_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/sorted_key_set_table.sv]
// Sorted key set table: a chain of cells holding up to DEPTH distinct nonzero
// keys in descending order, slot 0 holding the largest.
//
// Commands enter on start/cmd/key/index and are taken when start is high and
// busy is low. cmd selects lookup, insert or read at index. Every command gives
// one result beat on status/position/key_out/count, marked by done for one
// cycle; the receiver cannot stall, so the beat must be taken when it shows.
//
// Timing: in the accept cycle every cell compares its key with the probe and
// registers the outcome. In the next cycle (busy high) the position is decoded
// from the cells' flags, an insert shifts the cells below it one place in the
// same edge, and the result is registered. done is registered from that
// evaluation cycle, and busy holds off a new command until the evaluation
// is over, since the cell chain does its compare and its decode in turn.
//
// Reset clears every cell's valid bit and the key count, so the table starts
// empty at once and a command can be taken as soon as reset is released.
module sorted_key_set_table #(
    parameter int DEPTH     = sks_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = sks_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  cmd,
    input  logic [31:0] key,
    input  logic [5:0]  index,
    output logic        busy,
    output logic        done,
    output logic [1:0]  status,
    output logic [5:0]  position,
    output logic [31:0] key_out,
    output logic [6:0]  count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sks_pkg::seq_t      seq;
    sks_pkg::cell_ctl_t cell_ctl;

    logic [KEY_WIDTH-1:0] probe;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [1:0]           cmd_reg;
    logic [5:0]           idx_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    logic [KEY_WIDTH-1:0] slot_key [DEPTH];
    logic [DEPTH-1:0]     slot_valid;
    logic [DEPTH-1:0]     gt;
    logic [DEPTH-1:0]     eq;

    logic [PW-1:0]        at;
    logic                 hit;
    logic [KEY_WIDTH-1:0] rd_key;
    logic                 do_insert;

    logic                 done_reg;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [5:0]           position_reg;
    logic [5:0]           position_next;
    logic [31:0]          key_out_reg;
    logic [31:0]          key_out_next;
    logic [6:0]           count_out_reg;

    assign probe = KEY_WIDTH'(key);

    sks_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .seq   (seq)
    );

    assign cell_ctl.cmp_en   = seq.capture;
    assign cell_ctl.shift_en = seq.eval && do_insert;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            sks_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl),
                .probe      (probe),
                .ins_key    (key_reg),
                .left_key   ('0),
                .left_valid (1'b0),
                .left_gt    (1'b1),
                .slot_key   (slot_key[i]),
                .slot_valid (slot_valid[i]),
                .gt         (gt[i]),
                .eq         (eq[i])
            );
        end
        else
        begin : g_body
            sks_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl),
                .probe      (probe),
                .ins_key    (key_reg),
                .left_key   (slot_key[i-1]),
                .left_valid (slot_valid[i-1]),
                .left_gt    (gt[i-1]),
                .slot_key   (slot_key[i]),
                .slot_valid (slot_valid[i]),
                .gt         (gt[i]),
                .eq         (eq[i])
            );
        end
    end

    // The boundary between cells above the probe and the rest is one-hot or
    // empty, so its index and the read mux both reduce to plain OR trees.
    always_comb
    begin
        at     = '0;
        rd_key = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!gt[i] && ((i == 0) || gt[(i == 0) ? 0 : i - 1]))
            begin
                at = at | PW'(i);
            end
            if (int'(idx_reg) == i)
            begin
                rd_key = rd_key | slot_key[i];
            end
        end
    end

    assign hit = |eq;

    always_comb
    begin
        status_next   = sks_pkg::ST_INVALID;
        position_next = '0;
        key_out_next  = '0;
        count_next    = count_reg;
        do_insert     = 1'b0;
        case (cmd_reg)
            sks_pkg::CMD_LOOKUP,
            sks_pkg::CMD_INSERT:
            begin
                if (key_reg != '0)
                begin
                    if (hit)
                    begin
                        status_next   = sks_pkg::ST_OK;
                        position_next = 6'(at);
                    end
                    else if (cmd_reg == sks_pkg::CMD_LOOKUP)
                    begin
                        status_next = sks_pkg::ST_NOT_FOUND;
                    end
                    else if (int'(count_reg) >= DEPTH)
                    begin
                        status_next = sks_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next   = sks_pkg::ST_OK;
                        position_next = 6'(at);
                        count_next    = count_reg + CW'(1);
                        do_insert     = 1'b1;
                    end
                end
            end
            sks_pkg::CMD_READ:
            begin
                if (int'(idx_reg) < int'(count_reg))
                begin
                    status_next   = sks_pkg::ST_OK;
                    position_next = idx_reg;
                    key_out_next  = 32'(rd_key);
                end
            end
            default:
            begin
                status_next = sks_pkg::ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= seq.eval;
            if (seq.eval)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq.capture)
        begin
            key_reg <= probe;
            cmd_reg <= cmd;
            idx_reg <= index;
        end
        if (seq.eval)
        begin
            status_reg    <= status_next;
            position_reg  <= position_next;
            key_out_reg   <= key_out_next;
            count_out_reg <= 7'(count_next);
        end
    end

    assign busy     = seq.busy;
    assign done     = done_reg;
    assign status   = status_reg;
    assign position = position_reg;
    assign key_out  = key_out_reg;
    assign count    = count_out_reg;

    a_accept_then_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted command did not enter evaluation");

    a_done_after_eval : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result beat without a preceding evaluation cycle");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= DEPTH)
        else $error("key count above table depth");

    a_valid_matches_count : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid) == int'(count_reg))
        else $error("occupied cells disagree with key count");

    a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(seq.eval) && (count_reg == $past(count_reg) + CW'(1))))
        else $error("key count changed outside an insert");

endmodule

[dv/sorted_key_set_table_test.sv]
module sorted_key_set_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = sks_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_CMDS = 1800;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOWN_ERRORS = 10;

    // The block defines no code 3; it must be refused as invalid.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct
    {
        logic [1:0]  op;
        logic [31:0] key;
        logic [5:0]  index;
        int          gap;
    } table_cmd_t;

    typedef struct packed
    {
        logic [1:0]  status;
        logic [5:0]  position;
        logic [31:0] key_out;
        logic [6:0]  count;
    } table_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  cmd = sks_pkg::CMD_LOOKUP;
    logic [31:0] key = '0;
    logic [5:0]  index = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [5:0]  position;
    logic [31:0] key_out;
    logic [6:0]  count;

    // Shadow copy of the table contents.
    logic [31:0]  held_keys [TABLE_DEPTH];
    int           held_count = 0;

    table_cmd_t   cmd_queue [$];
    table_reply_t reply_queue [$];
    table_cmd_t   in_flight;
    logic [31:0]  used_keys [$];

    int  wait_cycles = 0;
    int  total_cmds = 0;
    int  cmds_accepted = 0;
    int  replies_seen = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  no_gaps = 1'b0;

    int  keys_placed = 0;
    int  lookup_hits = 0;
    int  reads_ok = 0;
    int  full_refusals = 0;
    int  invalid_cmds = 0;

    sorted_key_set_table DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .key      (key),
        .index    (index),
        .busy     (busy),
        .done     (done),
        .status   (status),
        .position (position),
        .key_out  (key_out),
        .count    (count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic table_reply_t apply_to_table(table_cmd_t c);
        table_reply_t r;
        int slot;
        int i;
        r = '0;
        r.status = sks_pkg::ST_INVALID;
        if ((c.op == sks_pkg::CMD_LOOKUP || c.op == sks_pkg::CMD_INSERT) && c.key != '0)
        begin
            // Keys are held in descending order, so the first slot not above
            // the probe is where it sits or where it belongs.
            slot = 0;
            while (slot < held_count && held_keys[slot] > c.key)
                slot++;
            if (slot < held_count && held_keys[slot] == c.key)
            begin
                r.status = sks_pkg::ST_OK;
                r.position = slot[5:0];
                if (c.op == sks_pkg::CMD_LOOKUP)
                    lookup_hits++;
            end
            else if (c.op == sks_pkg::CMD_LOOKUP)
            begin
                r.status = sks_pkg::ST_NOT_FOUND;
            end
            else if (held_count >= TABLE_DEPTH)
            begin
                r.status = sks_pkg::ST_FULL;
                full_refusals++;
            end
            else
            begin
                for (i = held_count; i > slot; i--)
                    held_keys[i] = held_keys[i - 1];
                held_keys[slot] = c.key;
                held_count++;
                keys_placed++;
                r.status = sks_pkg::ST_OK;
                r.position = slot[5:0];
            end
        end
        else if (c.op == sks_pkg::CMD_READ && c.index < held_count)
        begin
            r.status = sks_pkg::ST_OK;
            r.position = c.index;
            r.key_out = held_keys[c.index];
            reads_ok++;
        end
        if (r.status == sks_pkg::ST_INVALID)
            invalid_cmds++;
        r.count = held_count[6:0];
        return r;
    endfunction

    task automatic queue_cmd(logic [1:0] op, logic [31:0] k, logic [5:0] idx);
        table_cmd_t c;
        c.op = op;
        c.key = k;
        c.index = idx;
        c.gap = no_gaps ? 0 : $urandom_range(0, 3);
        cmd_queue.push_back(c);
        total_cmds++;
    endtask

    function automatic logic [31:0] fresh_key();
        logic [31:0] k;
        case ($urandom_range(0, 3))
            0: k = $urandom_range(1, 255);
            1: k = 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: k = $urandom();
        endcase
        used_keys.push_back(k);
        return k;
    endfunction

    // Mostly keys already handed out, so lookups and repeated inserts hit.
    function automatic logic [31:0] known_key();
        int roll;
        logic [31:0] k;
        roll = $urandom_range(0, 99);
        if (used_keys.size() == 0 || roll < 10)
            return $urandom();
        k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (roll < 17)
            return k + 32'd1;
        if (roll < 24)
            return k - 32'd1;
        if (roll < 27)
            return '0;
        return k;
    endfunction

    initial
    begin
        int n;
        int roll;
        int top;
        foreach (held_keys[i])
            held_keys[i] = '0;

        queue_cmd(sks_pkg::CMD_LOOKUP, 32'd5, '0);
        queue_cmd(sks_pkg::CMD_READ, '0, 6'd0);
        queue_cmd(CMD_UNUSED, '0, '0);
        queue_cmd(sks_pkg::CMD_LOOKUP, '0, '0);
        queue_cmd(sks_pkg::CMD_INSERT, '0, '0);
        queue_cmd(sks_pkg::CMD_INSERT, 32'hFFFF_FFFF, '0);
        queue_cmd(sks_pkg::CMD_INSERT, 32'd1, '0);
        queue_cmd(sks_pkg::CMD_INSERT, 32'h8000_0000, '0);
        queue_cmd(sks_pkg::CMD_INSERT, 32'hFFFF_FFFF, '0);
        queue_cmd(sks_pkg::CMD_INSERT, 32'h8000_0001, '0);
        queue_cmd(sks_pkg::CMD_LOOKUP, 32'd1, '0);
        queue_cmd(sks_pkg::CMD_LOOKUP, 32'd2, '0);
        queue_cmd(sks_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, '0);
        queue_cmd(sks_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, '0);
        queue_cmd(sks_pkg::CMD_READ, 32'hFFFF_FFFF, 6'd0);
        queue_cmd(sks_pkg::CMD_READ, '0, 6'd3);
        queue_cmd(sks_pkg::CMD_READ, '0, 6'd4);
        queue_cmd(sks_pkg::CMD_READ, '0, 6'd5);
        queue_cmd(sks_pkg::CMD_READ, '0, 6'd63);
        queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 6'd63);
        queue_cmd(sks_pkg::CMD_LOOKUP, 32'h8000_0000, 6'd63);
        used_keys.push_back(32'hFFFF_FFFF);
        used_keys.push_back(32'd1);
        used_keys.push_back(32'h8000_0000);
        used_keys.push_back(32'h8000_0001);

        // New keys come in slowly, so the table passes through every fill
        // level and then spends the tail of the run full.
        for (n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 150 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                queue_cmd(sks_pkg::CMD_LOOKUP, known_key(), 6'($urandom_range(0, 63)));
            end
            else if (roll < 60)
            begin
                if ($urandom_range(0, 99) < 20)
                    queue_cmd(sks_pkg::CMD_INSERT, fresh_key(),
                              6'($urandom_range(0, 63)));
                else
                    queue_cmd(sks_pkg::CMD_INSERT, known_key(),
                              6'($urandom_range(0, 63)));
            end
            else if (roll < 95)
            begin
                top = used_keys.size() > 63 ? 63 : used_keys.size();
                if ($urandom_range(0, 1) == 0)
                    queue_cmd(sks_pkg::CMD_READ, $urandom(), 6'($urandom_range(0, top)));
                else
                    queue_cmd(sks_pkg::CMD_READ, $urandom(), 6'($urandom_range(0, 63)));
            end
            else
            begin
                queue_cmd(CMD_UNUSED, $urandom(), 6'($urandom_range(0, 63)));
            end
        end

        wait (rst_n);
        while (cmds_accepted < total_cmds || reply_queue.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d commands: %0d keys placed, %0d lookup hits, %0d reads returned a key,",
                 cmds_accepted, keys_placed, lookup_hits, reads_ok);
        $display("%0d full-table refusals, %0d invalid; %0d keys held at the end",
                 full_refusals, invalid_cmds, held_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Command driver: one beat in flight, held until busy lets it through.
    always @(posedge clk)
    begin
        bit slot_free;
        if (rst_n)
        begin
            slot_free = !start || !busy;
            if (start && !busy)
            begin
                reply_queue.push_back(apply_to_table(in_flight));
                cmds_accepted++;
            end
            if (slot_free && cmd_queue.size() > 0 && wait_cycles >= cmd_queue[0].gap)
            begin
                in_flight = cmd_queue.pop_front();
                start <= 1'b1;
                cmd <= in_flight.op;
                key <= in_flight.key;
                index <= in_flight.index;
                wait_cycles = 0;
            end
            else if (slot_free)
            begin
                start <= 1'b0;
                if (cmd_queue.size() > 0)
                    wait_cycles++;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        table_reply_t seen;
        table_reply_t want;
        if (rst_n && done)
        begin
            seen = {status, position, key_out, count};
            if (reply_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_ERRORS)
                    $display("unexpected result beat: status %0d pos %0d key %h count %0d",
                             seen.status, seen.position, seen.key_out, seen.count);
            end
            else
            begin
                want = reply_queue.pop_front();
                if (seen != want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS)
                    begin
                        $display("result %0d: expected status %0d pos %0d key %h count %0d",
                                 replies_seen, want.status, want.position, want.key_out,
                                 want.count);
                        $display("result %0d:      got status %0d pos %0d key %h count %0d",
                                 replies_seen, seen.status, seen.position, seen.key_out,
                                 seen.count);
                    end
                end
            end
            replies_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d commands taken",
                     cycle_count, cmds_accepted, total_cmds);
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
